// File: rtl/seven_segment_odometer_overlay_top_defines.svh
`ifndef SEVEN_SEGMENT_ODOMETER_OVERLAY_TOP_DEFINES_SVH
`define SEVEN_SEGMENT_ODOMETER_OVERLAY_TOP_DEFINES_SVH

// Assertion wrappers; expect clk and rst in scope.
`define SSO_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

`define SSO_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/sso_pkg.sv
package sso_pkg;

  localparam int MAX_DIGITS   = 8;
  localparam int COORD_BITS   = 12;
  localparam int CNT_BITS     = 4;
  localparam int LEN_BITS     = 8;
  localparam int PITCH_BITS   = 10;
  localparam int GEOM_BITS    = 11;
  localparam int POS_BITS     = ((COORD_BITS > 13) ? COORD_BITS : 13) + 2;
  localparam int VALUE_BITS   = 27;
  localparam int BCD_DIGITS   = 8;
  localparam int BCD_IDX_BITS = $clog2(BCD_DIGITS);
  localparam int SEG_COUNT    = 7;
  localparam int SHADE_BITS   = 8;
  localparam int DATA_BITS    = 32;
  localparam int ADDR_BITS    = 5;
  localparam int BOX_MARGIN   = 5;
  localparam int BOX_RIGHT    = 10;

  localparam logic [VALUE_BITS-1:0] VALUE_LIMIT = VALUE_BITS'(99999999);
  localparam logic [SHADE_BITS-1:0] SHADE_LIT   = SHADE_BITS'(10);
  localparam logic [SHADE_BITS-1:0] SHADE_BOX   = SHADE_BITS'(230);

  typedef enum logic [2:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_DIGIT_COUNT,
    REG_SEG_LENGTH,
    REG_SEG_THICKNESS,
    REG_DIGIT_GAP,
    REG_SHOWN_VALUE
  } reg_idx_t;

  typedef logic signed [POS_BITS-1:0]  pos_t;
  typedef logic [SEG_COUNT-1:0]        seg_t;
  typedef logic [BCD_DIGITS-1:0][3:0]  bcd_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic                  covered;
    logic [SHADE_BITS-1:0] pixel_shade;
  } result_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] origin_x;
    logic [COORD_BITS-1:0] origin_y;
    logic [CNT_BITS-1:0]   digit_count;
    logic [LEN_BITS-1:0]   seg_length;
    logic [LEN_BITS-1:0]   seg_thickness;
    logic [LEN_BITS-1:0]   digit_gap;
    logic [VALUE_BITS-1:0] shown_value;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    origin_x:      '0,
    origin_y:      '0,
    digit_count:   CNT_BITS'(8),
    seg_length:    LEN_BITS'(20),
    seg_thickness: LEN_BITS'(4),
    digit_gap:     LEN_BITS'(4),
    shown_value:   '0
  };

  // Geometry derived from the registers; it follows them in the next cycle.
  typedef struct packed {
    logic [MAX_DIGITS-1:0][POS_BITS-1:0] left;
    logic [POS_BITS-1:0]  box_xlo;
    logic [POS_BITS-1:0]  box_xhi;
    logic [POS_BITS-1:0]  box_ylo;
    logic [POS_BITS-1:0]  box_yhi;
    logic [POS_BITS-1:0]  oy;
    logic [GEOM_BITS-1:0] t;
    logic [GEOM_BITS-1:0] tl;
    logic [GEOM_BITS-1:0] t2l;
    logic [GEOM_BITS-1:0] t2l2;
    logic [GEOM_BITS-1:0] t3l2;
    logic [CNT_BITS-1:0]  count;
  } geom_t;

  // bit 6 = a ... bit 0 = g
  function automatic seg_t seg_mask(logic [3:0] digit);
    seg_t m;
    case (digit)
      4'd0:    m = 7'b1111110;
      4'd1:    m = 7'b0110000;
      4'd2:    m = 7'b1101101;
      4'd3:    m = 7'b1111001;
      4'd4:    m = 7'b0110011;
      4'd5:    m = 7'b1011011;
      4'd6:    m = 7'b1011111;
      4'd7:    m = 7'b1110000;
      4'd8:    m = 7'b1111111;
      4'd9:    m = 7'b1111011;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/sso_regs.sv
module sso_regs import sso_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_BITS-1:0]  paddr,
  input  logic [DATA_BITS-1:0]  pwdata,
  output logic [DATA_BITS-1:0]  prdata,
  output logic                  pready,
  output geom_t                 geom,
  output logic [VALUE_BITS-1:0] shown_value
);

  cfg_t                  cfg;
  geom_t                 geom_next;
  reg_idx_t              idx;
  logic                  wr;
  logic [PITCH_BITS-1:0] pitch;
  logic [CNT_BITS-1:0]   count_eff;

  assign pready      = 1'b1;
  assign wr          = psel & penable & pwrite;
  assign idx         = reg_idx_t'(paddr[ADDR_BITS-1:2]);
  assign shown_value = cfg.shown_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr) begin
      unique case (idx)
        REG_ORIGIN_X:      cfg.origin_x      <= pwdata[COORD_BITS-1:0];
        REG_ORIGIN_Y:      cfg.origin_y      <= pwdata[COORD_BITS-1:0];
        REG_DIGIT_COUNT:   cfg.digit_count   <= pwdata[CNT_BITS-1:0];
        REG_SEG_LENGTH:    cfg.seg_length    <= pwdata[LEN_BITS-1:0];
        REG_SEG_THICKNESS: cfg.seg_thickness <= pwdata[LEN_BITS-1:0];
        REG_DIGIT_GAP:     cfg.digit_gap     <= pwdata[LEN_BITS-1:0];
        REG_SHOWN_VALUE:   cfg.shown_value   <= pwdata[VALUE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ORIGIN_X:      prdata = DATA_BITS'(cfg.origin_x);
      REG_ORIGIN_Y:      prdata = DATA_BITS'(cfg.origin_y);
      REG_DIGIT_COUNT:   prdata = DATA_BITS'(cfg.digit_count);
      REG_SEG_LENGTH:    prdata = DATA_BITS'(cfg.seg_length);
      REG_SEG_THICKNESS: prdata = DATA_BITS'(cfg.seg_thickness);
      REG_DIGIT_GAP:     prdata = DATA_BITS'(cfg.digit_gap);
      REG_SHOWN_VALUE:   prdata = DATA_BITS'(cfg.shown_value);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    pitch = PITCH_BITS'(cfg.seg_length) + PITCH_BITS'(cfg.seg_thickness)
          + PITCH_BITS'(cfg.digit_gap);
    count_eff = (cfg.digit_count > CNT_BITS'(MAX_DIGITS)) ? CNT_BITS'(MAX_DIGITS)
                                                          : cfg.digit_count;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      geom_next.left[d] = POS_BITS'(cfg.origin_x) + POS_BITS'(d) * POS_BITS'(pitch);
    end
    geom_next.t       = GEOM_BITS'(cfg.seg_thickness);
    geom_next.tl      = GEOM_BITS'(cfg.seg_thickness) + GEOM_BITS'(cfg.seg_length);
    geom_next.t2l     = geom_next.tl + GEOM_BITS'(cfg.seg_thickness);
    geom_next.t2l2    = geom_next.t2l + GEOM_BITS'(cfg.seg_length);
    geom_next.t3l2    = geom_next.t2l2 + GEOM_BITS'(cfg.seg_thickness);
    geom_next.oy      = POS_BITS'(cfg.origin_y);
    geom_next.box_xlo = POS_BITS'(cfg.origin_x) - POS_BITS'(BOX_MARGIN);
    geom_next.box_xhi = POS_BITS'(cfg.origin_x) + POS_BITS'(count_eff) * POS_BITS'(pitch)
                      + POS_BITS'(BOX_RIGHT);
    geom_next.box_ylo = POS_BITS'(cfg.origin_y) - POS_BITS'(BOX_MARGIN);
    geom_next.box_yhi = POS_BITS'(cfg.origin_y) + POS_BITS'(geom_next.t3l2)
                      + POS_BITS'(BOX_MARGIN);
    geom_next.count   = count_eff;
  end

  always_ff @(posedge clk) begin
    geom <= geom_next;
  end

endmodule

// File: rtl/sso_bcd.sv
`include "seven_segment_odometer_overlay_top_defines.svh"

module sso_bcd import sso_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VALUE_BITS-1:0] shown_value,
  output bcd_t                  digits
);

  localparam int DD_STAGES    = 3;
  localparam int DD_PER_STAGE = VALUE_BITS / DD_STAGES;

  typedef struct packed {
    bcd_t                  bcd;
    logic [VALUE_BITS-1:0] bin;
  } conv_t;

  conv_t conv      [DD_STAGES];
  conv_t conv_next [DD_STAGES];
  logic [VALUE_BITS-1:0] sat;

  function automatic conv_t dd_step(conv_t s);
    conv_t r;
    r = s;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (r.bcd[k] >= 4'd5) r.bcd[k] = r.bcd[k] + 4'd3;
    end
    r = conv_t'({r.bcd, r.bin} << 1);
    return r;
  endfunction

  function automatic logic digits_ok(bcd_t b);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < BCD_DIGITS; k++) begin
      if (b[k] > 4'd9) ok = 1'b0;
    end
    return ok;
  endfunction

  assign sat = (shown_value > VALUE_LIMIT) ? VALUE_LIMIT : shown_value;

  always_comb begin
    for (int s = 0; s < DD_STAGES; s++) begin
      if (s == 0) begin
        conv_next[s].bcd = '0;
        conv_next[s].bin = sat;
      end else begin
        conv_next[s] = conv[s-1];
      end
      for (int i = 0; i < DD_PER_STAGE; i++) begin
        conv_next[s] = dd_step(conv_next[s]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DD_STAGES; s++) conv[s] <= '0;
    end else begin
      for (int s = 0; s < DD_STAGES; s++) conv[s] <= conv_next[s];
    end
  end

  assign digits = conv[DD_STAGES-1].bcd;

  `SSO_ASSERT_ALWAYS(a_bcd_digits, digits_ok(digits), "decimal digit above nine")

endmodule

// File: rtl/sso_pixel.sv
`include "seven_segment_odometer_overlay_top_defines.svh"

module sso_pixel import sso_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  pixel_t  pixel,
  input  geom_t   geom,
  input  bcd_t    digits,
  output logic    done,
  output result_t result
);

  logic    s1_valid;
  pixel_t  s1_pix;

  logic    s2_valid;
  pos_t    s2_u      [MAX_DIGITS];
  pos_t    s2_u_next [MAX_DIGITS];
  pos_t    s2_v;
  pos_t    s2_v_next;
  logic    s2_box;
  logic    s2_box_next;

  logic    s3_valid;
  seg_t    s3_hit      [MAX_DIGITS];
  seg_t    s3_hit_next [MAX_DIGITS];
  logic    s3_box;

  logic    lit;
  logic    hit_any;
  result_t result_next;

  logic    shade_ok;
  logic    lit_out;

  // stage 1: capture
  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= in_valid;
    s1_pix <= pixel;
  end

  // stage 2: offsets from each digit cell and box test
  always_comb begin
    pos_t xs;
    pos_t ys;
    xs = signed'(POS_BITS'(s1_pix.pixel_x));
    ys = signed'(POS_BITS'(s1_pix.pixel_y));
    for (int d = 0; d < MAX_DIGITS; d++) begin
      s2_u_next[d] = xs - signed'(geom.left[d]);
    end
    s2_v_next   = ys - signed'(geom.oy);
    s2_box_next = (xs >= signed'(geom.box_xlo)) && (xs < signed'(geom.box_xhi)) &&
                  (ys >= signed'(geom.box_ylo)) && (ys < signed'(geom.box_yhi));
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
    s2_u   <= s2_u_next;
    s2_v   <= s2_v_next;
    s2_box <= s2_box_next;
  end

  // stage 3: segment rectangles under the pixel
  always_comb begin
    pos_t t;
    pos_t tl;
    pos_t t2l;
    pos_t t2l2;
    pos_t t3l2;
    logic v0, v1, v2, v3, v4;
    logic ua, ub, uc;
    t    = signed'(POS_BITS'(geom.t));
    tl   = signed'(POS_BITS'(geom.tl));
    t2l  = signed'(POS_BITS'(geom.t2l));
    t2l2 = signed'(POS_BITS'(geom.t2l2));
    t3l2 = signed'(POS_BITS'(geom.t3l2));
    v0 = !s2_v[POS_BITS-1] && (s2_v < t);
    v1 = (s2_v >= t)    && (s2_v < tl);
    v2 = (s2_v >= tl)   && (s2_v < t2l);
    v3 = (s2_v >= t2l)  && (s2_v < t2l2);
    v4 = (s2_v >= t2l2) && (s2_v < t3l2);
    for (int d = 0; d < MAX_DIGITS; d++) begin
      ua = !s2_u[d][POS_BITS-1] && (s2_u[d] < t);
      ub = (s2_u[d] >= t)  && (s2_u[d] < tl);
      uc = (s2_u[d] >= tl) && (s2_u[d] < t2l);
      s3_hit_next[d] = {ub & v0, uc & v1, uc & v3, ub & v4, ua & v3, ua & v1, ub & v2};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
    s3_hit <= s3_hit_next;
    s3_box <= s2_box;
  end

  // stage 4: digit values, lit test, shade
  always_comb begin
    logic [CNT_BITS-1:0] idx;
    logic [3:0]          digit;
    lit     = 1'b0;
    hit_any = 1'b0;
    for (int d = 0; d < MAX_DIGITS; d++) begin
      idx   = geom.count - CNT_BITS'(d) - CNT_BITS'(1);
      digit = '0;
      if (idx < CNT_BITS'(BCD_DIGITS)) digit = digits[idx[BCD_IDX_BITS-1:0]];
      if ((CNT_BITS'(d) < geom.count) && ((s3_hit[d] & seg_mask(digit)) != '0)) lit = 1'b1;
      if (s3_hit[d] != '0) hit_any = 1'b1;
    end
    result_next.covered     = lit | s3_box;
    result_next.pixel_shade = lit ? SHADE_LIT : (s3_box ? SHADE_BOX : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= s3_valid;
    result <= result_next;
  end

  assign shade_ok = result.covered ? ((result.pixel_shade == SHADE_LIT) ||
                                      (result.pixel_shade == SHADE_BOX))
                                   : (result.pixel_shade == '0);
  assign lit_out  = done && (result.pixel_shade == SHADE_LIT);

  `SSO_ASSERT_IMPLY(a_shade_code, done, shade_ok, "shade does not match coverage")
  `SSO_ASSERT_IMPLY(a_lit_has_hit, lit_out, $past(hit_any), "lit pixel without segment hit")

endmodule

// File: rtl/seven_segment_odometer_overlay_top.sv
// Seven-segment odometer overlay, evaluated per pixel.
// Pixel channel: drive start high with a coordinate on pixel; it is taken at
// every rising edge where start is high and busy is low. busy stays low, so a
// raster scan may present one pixel every clock.
// Result channel: done pulses for one cycle with covered and pixel_shade on
// result after the capture, offset, segment and result registers. Results
// leave in order; there is no back-pressure, the receiver must take each one.
// Throughput: one pixel per clock, set by the four-register pixel pipeline
// (capture, cell offsets, segment rectangles, digit lookup and shade).
// Configuration: APB writes at byte address 4*index; pready is always high.
// Geometry is registered from the new register values, the decimal value
// passes the three-stage binary to BCD pipeline; both are in time for a
// pixel taken in the cycle after the write.
// Reset (rst, synchronous) restores register defaults, clears the valid bits
// and the BCD pipeline; no result is produced until a pixel is taken.
module seven_segment_odometer_overlay_top import sso_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  pixel_t               pixel,
  output logic                 done,
  output result_t              result,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ADDR_BITS-1:0] paddr,
  input  logic [DATA_BITS-1:0] pwdata,
  output logic [DATA_BITS-1:0] prdata,
  output logic                 pready
);

  geom_t                 geom;
  bcd_t                  digits;
  logic [VALUE_BITS-1:0] shown_value;
  logic                  accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  sso_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .geom        (geom),
    .shown_value (shown_value)
  );

  sso_bcd u_bcd (
    .clk         (clk),
    .rst         (rst),
    .shown_value (shown_value),
    .digits      (digits)
  );

  sso_pixel u_pixel (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept),
    .pixel    (pixel),
    .geom     (geom),
    .digits   (digits),
    .done     (done),
    .result   (result)
  );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top import sso_pkg::*;;

  typedef enum int {SEG_A, SEG_B, SEG_C, SEG_D, SEG_E, SEG_F, SEG_G} seg_id_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  pixel_t               pixel = '0;
  logic                 done;
  result_t              result;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [ADDR_BITS-1:0] paddr = '0;
  logic [DATA_BITS-1:0] pwdata = '0;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  cfg_t    overlay_cfg = CFG_RESET;
  result_t predicted_shades[$];
  int      mismatch_count = 0;

  seven_segment_odometer_overlay_top u_top (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .pixel   (pixel),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // bit 6 = a ... bit 0 = g
  function automatic logic [6:0] digit_segments(int digit);
    logic [6:0] m;
    case (digit)
      0:       m = 7'h7E;
      1:       m = 7'h30;
      2:       m = 7'h6D;
      3:       m = 7'h79;
      4:       m = 7'h33;
      5:       m = 7'h5B;
      6:       m = 7'h5F;
      7:       m = 7'h70;
      8:       m = 7'h7F;
      default: m = 7'h7B;
    endcase
    return m;
  endfunction

  function automatic bit in_rect(int u, int v, int u0, int uw, int v0, int vh);
    return u >= u0 && u < u0 + uw && v >= v0 && v < v0 + vh;
  endfunction

  function automatic int shown_digits();
    return (overlay_cfg.digit_count > MAX_DIGITS) ? MAX_DIGITS : int'(overlay_cfg.digit_count);
  endfunction

  function automatic int digit_pitch();
    return int'(overlay_cfg.seg_length) + int'(overlay_cfg.seg_thickness) +
           int'(overlay_cfg.digit_gap);
  endfunction

  function automatic result_t predict_overlay(pixel_t p);
    int          x, y, ox, oy, len, thk, pitch, cnt, u, v, d;
    int unsigned val;
    logic [6:0]  m;
    bit          lit, in_box;
    result_t     r;
    x     = int'(p.pixel_x);
    y     = int'(p.pixel_y);
    ox    = int'(overlay_cfg.origin_x);
    oy    = int'(overlay_cfg.origin_y);
    len   = int'(overlay_cfg.seg_length);
    thk   = int'(overlay_cfg.seg_thickness);
    pitch = digit_pitch();
    cnt   = shown_digits();
    val   = (overlay_cfg.shown_value > VALUE_LIMIT) ? int'(VALUE_LIMIT)
                                                    : int'(overlay_cfg.shown_value);
    lit   = 1'b0;
    for (d = cnt - 1; d >= 0; d--) begin
      m   = digit_segments(val % 10);
      val = val / 10;
      u   = x - (ox + d * pitch);
      v   = y - oy;
      if (m[6] && in_rect(u, v, thk, len, 0, thk)) lit = 1'b1;
      if (m[5] && in_rect(u, v, thk + len, thk, thk, len)) lit = 1'b1;
      if (m[4] && in_rect(u, v, thk + len, thk, 2 * thk + len, len)) lit = 1'b1;
      if (m[3] && in_rect(u, v, thk, len, 2 * thk + 2 * len, thk)) lit = 1'b1;
      if (m[2] && in_rect(u, v, 0, thk, 2 * thk + len, len)) lit = 1'b1;
      if (m[1] && in_rect(u, v, 0, thk, thk, len)) lit = 1'b1;
      if (m[0] && in_rect(u, v, thk, len, thk + len, thk)) lit = 1'b1;
    end
    in_box = x >= ox - BOX_MARGIN && x < ox + cnt * pitch + BOX_RIGHT &&
             y >= oy - BOX_MARGIN && y < oy + 3 * thk + 2 * len + BOX_MARGIN;
    if (lit) begin
      r.covered     = 1'b1;
      r.pixel_shade = SHADE_LIT;
    end else if (in_box) begin
      r.covered     = 1'b1;
      r.pixel_shade = SHADE_BOX;
    end else begin
      r.covered     = 1'b0;
      r.pixel_shade = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && done) begin
      if (predicted_shades.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual covered=%0d shade=%0d",
                 $time, result.covered, result.pixel_shade);
        mismatch_count++;
      end else begin
        want = predicted_shades.pop_front();
        if (result.covered !== want.covered) begin
          $display("%0t: covered mismatch, expected %0d actual %0d",
                   $time, want.covered, result.covered);
          mismatch_count++;
        end
        if (result.pixel_shade !== want.pixel_shade) begin
          $display("%0t: pixel_shade mismatch, expected %0d actual %0d",
                   $time, want.pixel_shade, result.pixel_shade);
          mismatch_count++;
        end
      end
    end
  end

  function automatic pixel_t pixel_at(int x, int y);
    pixel_t p;
    p.pixel_x = COORD_BITS'(x);
    p.pixel_y = COORD_BITS'(y);
    return p;
  endfunction

  // centre of one segment of the digit at position digit_pos
  function automatic pixel_t segment_pixel(int digit_pos, seg_id_t s);
    int len, thk, u, v, left;
    len  = int'(overlay_cfg.seg_length);
    thk  = int'(overlay_cfg.seg_thickness);
    left = int'(overlay_cfg.origin_x) + digit_pos * digit_pitch();
    case (s)
      SEG_A:   begin u = thk + len / 2;       v = thk / 2;                   end
      SEG_B:   begin u = thk + len + thk / 2; v = thk + len / 2;             end
      SEG_C:   begin u = thk + len + thk / 2; v = 2 * thk + len + len / 2;   end
      SEG_D:   begin u = thk + len / 2;       v = 2 * thk + 2 * len + thk / 2; end
      SEG_E:   begin u = thk / 2;             v = 2 * thk + len + len / 2;   end
      SEG_F:   begin u = thk / 2;             v = thk + len / 2;             end
      default: begin u = thk + len / 2;       v = thk + len + thk / 2;       end
    endcase
    return pixel_at(left + u, int'(overlay_cfg.origin_y) + v);
  endfunction

  function automatic pixel_t random_pixel();
    int     cnt, pitch, ox, oy, sel;
    pixel_t p;
    cnt   = shown_digits();
    pitch = digit_pitch();
    ox    = int'(overlay_cfg.origin_x);
    oy    = int'(overlay_cfg.origin_y);
    sel   = $urandom_range(0, 19);
    if (sel < 12 && cnt > 0) begin
      p = segment_pixel($urandom_range(0, cnt - 1), seg_id_t'($urandom_range(0, 6)));
      p.pixel_x = p.pixel_x + COORD_BITS'($urandom_range(0, 2)) - COORD_BITS'(1);
      p.pixel_y = p.pixel_y + COORD_BITS'($urandom_range(0, 2)) - COORD_BITS'(1);
    end else if (sel < 17) begin
      p = pixel_at(ox - 8 + int'($urandom_range(0, cnt * pitch + 22)),
                   oy - 8 + int'($urandom_range(0, 3 * int'(overlay_cfg.seg_thickness) +
                                                   2 * int'(overlay_cfg.seg_length) + 16)));
    end else begin
      p = {COORD_BITS'($urandom), COORD_BITS'($urandom)};
    end
    return p;
  endfunction

  function automatic cfg_t make_frame(int ox, int oy, int cnt, int len, int thk, int gap,
                                      int val);
    cfg_t c;
    c.origin_x      = COORD_BITS'(ox);
    c.origin_y      = COORD_BITS'(oy);
    c.digit_count   = CNT_BITS'(cnt);
    c.seg_length    = LEN_BITS'(len);
    c.seg_thickness = LEN_BITS'(thk);
    c.digit_gap     = LEN_BITS'(gap);
    c.shown_value   = VALUE_BITS'(val);
    return c;
  endfunction

  function automatic int pick_field(int lo, int hi, int top);
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return 0;
    if (r == 1) return top;
    return $urandom_range(lo, hi);
  endfunction

  function automatic cfg_t random_frame();
    return make_frame(pick_field(0, 3000, 4095), pick_field(0, 3000, 4095),
                      pick_field(1, 8, 15), pick_field(1, 24, 255), pick_field(1, 8, 255),
                      pick_field(0, 8, 255), pick_field(0, 99999999, 134217727));
  endfunction

  task automatic send_pixel(pixel_t p);
    start <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (busy);
    predicted_shades.push_back(predict_overlay(p));
  endtask

  task automatic idle_for(int n);
    start <= 1'b0;
    pixel <= {COORD_BITS'($urandom), COORD_BITS'($urandom)};
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (predicted_shades.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [DATA_BITS-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic load_frame(cfg_t c);
    wait_drained();
    write_reg(REG_ORIGIN_X,      DATA_BITS'(c.origin_x));
    write_reg(REG_ORIGIN_Y,      DATA_BITS'(c.origin_y));
    write_reg(REG_DIGIT_COUNT,   DATA_BITS'(c.digit_count));
    write_reg(REG_SEG_LENGTH,    DATA_BITS'(c.seg_length));
    write_reg(REG_SEG_THICKNESS, DATA_BITS'(c.seg_thickness));
    write_reg(REG_DIGIT_GAP,     DATA_BITS'(c.digit_gap));
    write_reg(REG_SHOWN_VALUE,   DATA_BITS'(c.shown_value));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    overlay_cfg = c;
  endtask

  task automatic test_reset_state();
    send_pixel(pixel_at(0, 0));
    send_pixel(pixel_at(4, 0));
    send_pixel(pixel_at(233, 56));
    send_pixel(pixel_at(234, 56));
    send_pixel(pixel_at(4095, 4095));
  endtask

  task automatic test_digit_patterns();
    int d;
    load_frame(make_frame(20, 10, 8, 8, 3, 2, 98765432));
    for (d = 0; d < 8; d++) send_pixel(segment_pixel(d, seg_id_t'(d % 7)));
    send_pixel(segment_pixel(0, SEG_E));
    send_pixel(segment_pixel(7, SEG_C));
  endtask

  task automatic test_special_cases();
    // digit count above the maximum, value above the limit
    load_frame(make_frame(100, 50, 15, 6, 2, 1, 134217727));
    send_pixel(segment_pixel(7, SEG_G));
    send_pixel(pixel_at(181, 50));
    send_pixel(pixel_at(182, 50));
    // no digits: box only
    load_frame(make_frame(200, 200, 0, 10, 3, 2, 12345));
    send_pixel(segment_pixel(0, SEG_A));
    send_pixel(pixel_at(209, 200));
    send_pixel(pixel_at(210, 200));
    // zero length, then zero thickness
    load_frame(make_frame(10, 10, 2, 0, 5, 1, 88));
    send_pixel(segment_pixel(0, SEG_A));
    send_pixel(segment_pixel(1, SEG_F));
    load_frame(make_frame(10, 10, 2, 7, 0, 1, 88));
    send_pixel(segment_pixel(0, SEG_G));
    // thick segments: lit outside the box, and lit from the previous cell
    load_frame(make_frame(300, 300, 2, 2, 60, 0, 81));
    send_pixel(segment_pixel(1, SEG_B));
    send_pixel(segment_pixel(0, SEG_B));
  endtask

  task automatic test_random_frames();
    int frame, i;
    bit may_idle;
    for (frame = 0; frame < 25; frame++) begin
      if (frame == 0) begin
        load_frame(make_frame(4095, 4095, 15, 255, 255, 255, 134217727));
      end else if (frame == 1) begin
        load_frame(make_frame(0, 0, 0, 0, 0, 0, 0));
      end else begin
        load_frame(random_frame());
      end
      may_idle = (frame < 21) && (frame % 4 != 3);
      for (i = 0; i < 50; i++) begin
        send_pixel(random_pixel());
        if (may_idle && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_digit_patterns();
    test_special_cases();
    test_random_frames();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
